### hdl/ups_ps_pkg.sv
package ups_ps_pkg;

  localparam int unsigned MvW    = 13;
  localparam int unsigned BootW  = 5;
  localparam int unsigned CountW = 8;
  localparam int unsigned SumW   = CountW + 4;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_SHUT = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_SHUTDOWN_LEVEL = 3'd0,
    REG_USER_LEVEL     = 3'd1,
    REG_POWER_ON_LEVEL = 3'd2,
    REG_BOOT_PERIODS   = 3'd3,
    REG_SHUTDOWN_SECS  = 3'd4,
    REG_HOLD_SAMPLES   = 3'd5
  } reg_idx_e;

  localparam logic [MvW-1:0]    RstShutdownLevel = 13'd3000;
  localparam logic [MvW-1:0]    RstUserLevel     = 13'd3500;
  localparam logic [MvW-1:0]    RstPowerOnLevel  = 13'd4300;
  localparam logic [BootW-1:0]  RstBootPeriods   = 5'd8;
  localparam logic [CountW-1:0] RstShutdownSecs  = 8'd30;
  localparam logic [CountW-1:0] RstHoldSamples   = 8'd20;

  localparam logic [CountW-1:0] CountMax = 8'd255;

endpackage

### hdl/ups_power_supervisor_core.sv
// A request accepted on the slave side waits in the input stage until the result
// register is free, is loaded into it, and is taken from there on the master side.
// Throughput: one request per cycle unless the master side stalls; each state
// update is one pass of compares, an 8-bit decrement and a 12-bit saturating add.
// Reset (rst_ni low, asynchronous): mode off, auto power-on set, timer and LED
// cleared, both pipeline stages empty, registers back to their defaults.
module ups_power_supervisor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [12:0] vcc_mv, [13] request_now, [21:14] request_held, [23:22] zero
  input  logic [23:0] s_axis_tdata,
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] boost_enable, [1] shutdown_line, [2] status_led, [4:3] mode,
  // [5] shutdown_line (a copy of bit 1), [13:6] timer_left, [15:14] zero
  output logic [15:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned MvW    = ups_ps_pkg::MvW;
  localparam int unsigned BootW  = ups_ps_pkg::BootW;
  localparam int unsigned CountW = ups_ps_pkg::CountW;
  localparam int unsigned SumW   = ups_ps_pkg::SumW;

  // configuration registers
  logic [MvW-1:0]    shutdown_level_q, user_level_q, power_on_level_q;
  logic [BootW-1:0]  boot_periods_q;
  logic [CountW-1:0] shutdown_secs_q, hold_samples_q;

  ups_ps_pkg::reg_idx_e cfg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = ups_ps_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shutdown_level_q <= ups_ps_pkg::RstShutdownLevel;
      user_level_q     <= ups_ps_pkg::RstUserLevel;
      power_on_level_q <= ups_ps_pkg::RstPowerOnLevel;
      boot_periods_q   <= ups_ps_pkg::RstBootPeriods;
      shutdown_secs_q  <= ups_ps_pkg::RstShutdownSecs;
      hold_samples_q   <= ups_ps_pkg::RstHoldSamples;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ups_ps_pkg::REG_SHUTDOWN_LEVEL: shutdown_level_q <= pwdata[MvW-1:0];
        ups_ps_pkg::REG_USER_LEVEL:     user_level_q     <= pwdata[MvW-1:0];
        ups_ps_pkg::REG_POWER_ON_LEVEL: power_on_level_q <= pwdata[MvW-1:0];
        ups_ps_pkg::REG_BOOT_PERIODS:   boot_periods_q   <= pwdata[BootW-1:0];
        ups_ps_pkg::REG_SHUTDOWN_SECS:  shutdown_secs_q  <= pwdata[CountW-1:0];
        ups_ps_pkg::REG_HOLD_SAMPLES:   hold_samples_q   <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ups_ps_pkg::REG_SHUTDOWN_LEVEL: prdata = {19'd0, shutdown_level_q};
      ups_ps_pkg::REG_USER_LEVEL:     prdata = {19'd0, user_level_q};
      ups_ps_pkg::REG_POWER_ON_LEVEL: prdata = {19'd0, power_on_level_q};
      ups_ps_pkg::REG_BOOT_PERIODS:   prdata = {27'd0, boot_periods_q};
      ups_ps_pkg::REG_SHUTDOWN_SECS:  prdata = {24'd0, shutdown_secs_q};
      ups_ps_pkg::REG_HOLD_SAMPLES:   prdata = {24'd0, hold_samples_q};
      default:                        prdata = 32'd0;
    endcase
  end

  // input stage
  logic              in_valid_q;
  logic [MvW-1:0]    vcc_q;
  logic              req_now_q;
  logic [CountW-1:0] req_held_q;
  logic              out_free;
  logic              advance;
  logic              s_accept;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      vcc_q      <= s_axis_tdata[12:0];
      req_now_q  <= s_axis_tdata[13];
      req_held_q <= s_axis_tdata[21:14];
    end
  end

  // supervisor state
  ups_ps_pkg::mode_e mode_q, mode_d;
  logic              auto_on_q, auto_on_d;
  logic [CountW-1:0] count_q, count_d;
  logic              led_q, led_d;

  logic [CountW-1:0] need;
  logic              power_on;
  logic              go;
  logic [SumW-1:0]   sum;

  always_comb begin
    mode_d    = mode_q;
    auto_on_d = auto_on_q;
    count_d   = count_q;
    led_d     = led_q;
    power_on  = 1'b0;
    go        = 1'b0;
    sum       = '0;
    need      = (hold_samples_q == '0) ? CountW'(1) : hold_samples_q;

    // shutdown tick; an unused mode code falls back to off
    case (mode_q)
      ups_ps_pkg::MODE_SHUT: begin
        if (count_q <= CountW'(1)) begin
          count_d = '0;
          mode_d  = ups_ps_pkg::MODE_OFF;
        end else begin
          count_d = count_q - CountW'(1);
          led_d   = ~led_q;
        end
      end
      ups_ps_pkg::MODE_ON:  mode_d = ups_ps_pkg::MODE_ON;
      ups_ps_pkg::MODE_OFF: mode_d = ups_ps_pkg::MODE_OFF;
      default:              mode_d = ups_ps_pkg::MODE_OFF;
    endcase

    if (mode_d == ups_ps_pkg::MODE_OFF) begin
      power_on = (auto_on_q && vcc_q >= power_on_level_q) ||
                 (req_now_q && vcc_q >= user_level_q);
      led_d = power_on;
      if (power_on) begin
        mode_d    = ups_ps_pkg::MODE_ON;
        auto_on_d = 1'b1;
        count_d   = CountW'(boot_periods_q);
      end
    end

    if (mode_d == ups_ps_pkg::MODE_ON) begin
      if (vcc_q < shutdown_level_q) begin
        go = 1'b1;
      end else if (req_now_q && req_held_q >= need) begin
        go        = 1'b1;
        auto_on_d = 1'b0;
      end else if (count_d != '0) begin
        count_d = count_d - CountW'(1);
      end
      if (go) begin
        // leftover boot periods are eight seconds each
        sum = {1'b0, count_d, 3'b000} + SumW'(shutdown_secs_q);
        if (sum > SumW'(ups_ps_pkg::CountMax)) begin
          count_d = ups_ps_pkg::CountMax;
        end else if (sum == '0) begin
          count_d = CountW'(1);
        end else begin
          count_d = sum[CountW-1:0];
        end
        mode_d = ups_ps_pkg::MODE_SHUT;
        led_d  = ~led_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ups_ps_pkg::MODE_OFF;
      auto_on_q <= 1'b1;
      count_q   <= '0;
      led_q     <= 1'b0;
    end else if (advance) begin
      mode_q    <= mode_d;
      auto_on_q <= auto_on_d;
      count_q   <= count_d;
      led_q     <= led_d;
    end
  end

  // result register
  logic shut_d;

  assign shut_d = (mode_d == ups_ps_pkg::MODE_SHUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_axis_tdata <= {2'b00, count_d, shut_d, mode_d, led_d, shut_d,
                       mode_d != ups_ps_pkg::MODE_OFF};
    end
  end

  // a shutdown in progress always has time left on it
  a_shut_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ups_ps_pkg::MODE_SHUT |-> count_q != '0)
    else $error("shutdown mode with an empty timer");

  // the slave side only stalls when both stages are full and the master stalls
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && m_axis_tvalid && !m_axis_tready))
    else $error("slave side stalled without a full pipeline");

  // state moves only when a request passes into the result register
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(mode_q) && $stable(count_q) && $stable(led_q)))
    else $error("supervisor state changed without a request");

  // auto power-on is cleared only by a manual shutdown
  a_auto_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (auto_on_q && !auto_on_d && advance) |=> mode_q == ups_ps_pkg::MODE_SHUT)
    else $error("auto power-on cleared outside a manual shutdown");

endmodule
